// ----- design/adpl_pkg.sv -----
// Shared types, status codes and constants for the archive directory parser.
// No dependencies; imported by every module of the block.
package adpl_pkg;

    localparam logic [31:0] HDR_BYTES = 32'd32;
    localparam logic [31:0] REC_BYTES = 32'd8;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_QUERY   = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [3:0] ST_ACCEPTED   = 4'd0;
    localparam logic [3:0] ST_READY      = 4'd1;
    localparam logic [3:0] ST_HIT        = 4'd2;
    localparam logic [3:0] ST_MISS       = 4'd3;
    localparam logic [3:0] ST_IGNORED    = 4'd4;
    localparam logic [3:0] ST_E_SHORT    = 4'd5;
    localparam logic [3:0] ST_E_DIR      = 4'd6;
    localparam logic [3:0] ST_E_TBL_PAST = 4'd7;
    localparam logic [3:0] ST_E_TBL_END  = 4'd8;
    localparam logic [3:0] ST_E_DATA     = 4'd9;
    localparam logic [3:0] ST_E_DECR     = 4'd10;
    localparam logic [3:0] ST_E_FIRST    = 4'd11;
    localparam logic [3:0] ST_E_LAST     = 4'd12;
    localparam logic [3:0] ST_E_PARTIAL  = 4'd13;
    localparam logic [3:0] ST_E_INDEX    = 4'd14;
    localparam logic [3:0] ST_E_CAP      = 4'd15;
    localparam logic [3:0] ERR_NONE      = 4'd0;

    localparam logic [2:0] HW_MAGIC   = 3'd2;
    localparam logic [2:0] HW_DIRSIZE = 3'd3;
    localparam logic [2:0] HW_TBLBEG  = 3'd4;
    localparam logic [2:0] HW_ENTRIES = 3'd5;
    localparam logic [2:0] HW_DATABEG = 3'd6;
    localparam logic [2:0] HW_DATASZ  = 3'd7;

    typedef enum logic [2:0] {
        PH_LOAD  = 3'b001,
        PH_READY = 3'b010,
        PH_FAIL  = 3'b100
    } t_phase;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN1 = 7'b0000010,
        S_SCAN2 = 7'b0000100,
        S_RDA   = 7'b0001000,
        S_RDB   = 7'b0010000,
        S_RDC   = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    // Keep the lower of the held and the new error code.
    function automatic logic [3:0] note_err(input logic [3:0] cur, input logic [3:0] code);
        return (cur == ERR_NONE || code < cur) ? code : cur;
    endfunction

endpackage

// ----- design/adpl_cfg_regs.sv -----
// APB register slice holding the archive size register.
// Depends on adpl_pkg only through the common import convention.
module adpl_cfg_regs
    import adpl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] o_archive_size
);

    logic [31:0] r_archive_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_archive_size <= '0;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_archive_size <= pwdata;
        end
    end

    assign pready         = 1'b1;
    assign prdata         = paddr[2] ? 32'd0 : r_archive_size;
    assign o_archive_size = r_archive_size;

endmodule

// ----- design/archive_directory_parse_and_lookup_top.sv -----
// Top level of the archive directory parser and resource lookup.
// Depends on adpl_pkg and adpl_cfg_regs.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall) carries one item per transfer:
//    an archive byte, a lookup query, or a restart. Output channel
//    (o_out_valid / i_out_stall) returns exactly one result per item.
//  - For archive bytes and restarts, the result lands in the output
//    register the cycle after the transfer.
//  - A lookup walks the directory memory through its single read port
//    (best match, then, if found, run bound) and, for an in-range candidate,
//    reads the offset memory twice; a walk covers the whole records (at most
//    MAX_RECORDS). Input stays stalled until the lookup result is loaded.
//  - A new item is taken while a finished result still waits, as long as
//    the output register is free or being emptied in that cycle.
//  - Reset clears the parse state, the register and the output; the two
//    memories are not cleared, they are always written before being read.
//  - A stalled receiver holds the output register and, through it, stalls
//    the input side.
//  - The user must write archive_size over APB only while the block is idle; the block does not enforce it.
module archive_directory_parse_and_lookup_top
    import adpl_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_RECORDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_byte_value,
    input  logic [15:0] i_query_type,
    input  logic [15:0] i_query_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_status,
    output logic [9:0]  o_entry_number,
    output logic [31:0] o_entry_offset,
    output logic [31:0] o_entry_size,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int OAW = $clog2(MAX_ENTRIES + 1);
    localparam int RAW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int NRW = $clog2(MAX_RECORDS + 1);

    logic [31:0] archive_size;

    adpl_cfg_regs u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_archive_size (archive_size)
    );

    // Parse state
    t_phase      r_phase, n_phase;
    logic [31:0] r_bytes_seen, n_bytes_seen;
    logic [31:0] r_word, n_word;
    logic [31:0] r_dir_bytes, n_dir_bytes;
    logic [31:0] r_table_begin, n_table_begin;
    logic [31:0] r_entry_total, n_entry_total;
    logic [31:0] r_payload_start, n_payload_start;
    logic [3:0]  r_pending, n_pending;
    logic [31:0] r_prev_off, n_prev_off;
    logic [31:0] r_rec_lo, n_rec_lo;
    logic [3:0]  byte_status;

    // Memories
    logic [47:0] dir_mem [MAX_RECORDS];
    logic [31:0] off_mem [MAX_ENTRIES + 1];
    logic          dir_we, off_we;
    logic [RAW-1:0] dir_wa;
    logic [47:0]   dir_wd;
    logic [OAW-1:0] off_wa;
    logic          dir_re, off_re;
    logic [RAW-1:0] dir_ra;
    logic [OAW-1:0] off_ra;
    logic [47:0]   r_dir_q;
    logic [31:0]   r_off_q;
    logic          r_dq_vld;

    // Lookup state
    t_state      r_state;
    logic [15:0] r_qtype, r_qid;
    logic [NRW-1:0] r_scan_i;
    logic        r_found;
    logic [15:0] r_best_id, r_best_idx;
    logic [31:0] r_bound;
    logic [17:0] r_cand;
    logic [31:0] r_lk_off;
    logic [3:0]  r_lk_status;
    logic [31:0] r_lk_size;

    // Output register
    logic        r_out_vld;
    logic [3:0]  r_out_status;
    logic [9:0]  r_out_num;
    logic [31:0] r_out_off, r_out_size;

    logic        out_free, in_xfer, byte_take, out_load;
    logic [NRW-1:0] rec_cnt;
    logic [17:0] cand_calc;
    logic [17:0] cand_next;
    logic        scan_done;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign byte_take  = in_xfer && (i_kind == KIND_BYTE) && (r_phase == PH_LOAD);
    assign rec_cnt    = r_dir_bytes[NRW+2:3];

    // Load the output register for every item except a lookup that starts a walk,
    // and again when the walk finishes.
    assign out_load = ((r_state == S_IDLE) && in_xfer &&
                       !(i_kind == KIND_QUERY && r_phase == PH_READY)) ||
                      ((r_state == S_FIN) && out_free);

    // Byte parser: next parse state for one archive byte.
    always_comb begin
        logic [31:0] p, w, rel, k;
        logic [34:0] tend;
        logic [3:0]  pe;
        p = r_bytes_seen;
        w = {i_byte_value, r_word[31:8]};
        rel = '0;
        k = '0;
        tend = '0;
        pe = r_pending;
        n_phase = r_phase;
        n_bytes_seen = r_bytes_seen;
        n_word = r_word;
        n_dir_bytes = r_dir_bytes;
        n_table_begin = r_table_begin;
        n_entry_total = r_entry_total;
        n_payload_start = r_payload_start;
        n_pending = r_pending;
        n_prev_off = r_prev_off;
        n_rec_lo = r_rec_lo;
        byte_status = ST_ACCEPTED;
        dir_we = 1'b0;
        dir_wa = '0;
        dir_wd = {16'd0, r_rec_lo};
        off_we = 1'b0;
        off_wa = '0;
        if (archive_size < HDR_BYTES) begin
            n_phase = PH_FAIL;
            byte_status = ST_E_SHORT;
        end else begin
            n_word = w;
            n_bytes_seen = p + 32'd1;
            if (p < HDR_BYTES) begin
                if (p[1:0] == 2'd3) begin
                    case (p[4:2])
                        HW_MAGIC: begin
                            if (w != HDR_BYTES) n_pending = note_err(r_pending, ST_E_DIR);
                        end
                        HW_DIRSIZE: n_dir_bytes = w;
                        HW_TBLBEG: begin
                            n_table_begin = w;
                            if (w != HDR_BYTES + r_dir_bytes)
                                n_pending = note_err(r_pending, ST_E_DIR);
                        end
                        HW_ENTRIES: n_entry_total = w;
                        HW_DATABEG: n_payload_start = w;
                        HW_DATASZ: begin
                            tend = {3'd0, r_table_begin}
                                 + {33'({1'b0, r_entry_total} + 33'd1), 2'b00};
                            if (r_pending == ST_E_DIR) begin
                                n_phase = PH_FAIL;
                                byte_status = ST_E_DIR;
                            end else if (tend > {3'd0, archive_size}) begin
                                n_phase = PH_FAIL;
                                byte_status = ST_E_TBL_PAST;
                            end else if (tend != {3'd0, r_payload_start}) begin
                                n_phase = PH_FAIL;
                                byte_status = ST_E_TBL_END;
                            end else if ({1'b0, r_payload_start} + {1'b0, w}
                                         != {1'b0, archive_size}) begin
                                n_phase = PH_FAIL;
                                byte_status = ST_E_DATA;
                            end else if (r_entry_total > 32'(MAX_ENTRIES) ||
                                         (r_dir_bytes >> 3) > 32'(MAX_RECORDS)) begin
                                n_phase = PH_FAIL;
                                byte_status = ST_E_CAP;
                            end else begin
                                n_pending = (r_dir_bytes[2:0] != 3'd0) ? ST_E_PARTIAL
                                                                       : ERR_NONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end else if (p < r_table_begin) begin
                rel = p - HDR_BYTES;
                k = rel >> 3;
                if (k < 32'(MAX_RECORDS)) begin
                    if (rel[2:0] == 3'd3) begin
                        n_rec_lo = w;
                    end else if (rel[2:0] == 3'd7) begin
                        dir_we = 1'b1;
                        dir_wa = k[RAW-1:0];
                        dir_wd = {w[31:16], r_rec_lo};
                        if (r_pending != ST_E_PARTIAL && {16'd0, w[31:16]} >= r_entry_total)
                            n_pending = note_err(r_pending, ST_E_INDEX);
                    end
                end
            end else begin
                rel = p - r_table_begin;
                k = rel >> 2;
                if (rel[1:0] == 2'd3 && k <= 32'(MAX_ENTRIES) && k <= r_entry_total) begin
                    off_we = 1'b1;
                    off_wa = k[OAW-1:0];
                    n_prev_off = w;
                    if (k != 32'd0 && w < r_prev_off) pe = note_err(pe, ST_E_DECR);
                    if (k == 32'd0 && w != r_payload_start) pe = note_err(pe, ST_E_FIRST);
                    if (k == r_entry_total) begin
                        if (w != archive_size) pe = note_err(pe, ST_E_LAST);
                        if (pe != ERR_NONE) begin
                            n_phase = PH_FAIL;
                            byte_status = pe;
                        end else begin
                            n_phase = PH_READY;
                            byte_status = ST_READY;
                        end
                    end
                    n_pending = pe;
                end
            end
        end
    end

    // Memory read ports: directory walk and offset fetch.
    assign dir_re = (r_state == S_SCAN1 || r_state == S_SCAN2) && (r_scan_i < rec_cnt);
    assign dir_ra = r_scan_i[RAW-1:0];
    assign off_re = (r_state == S_RDA) || (r_state == S_RDB);
    assign cand_next = r_cand + 18'd1;
    assign off_ra = (r_state == S_RDA) ? r_cand[OAW-1:0] : cand_next[OAW-1:0];
    assign scan_done = !dir_re && !r_dq_vld;
    assign cand_calc = {2'd0, r_best_idx} + ({2'd0, r_qid} - {2'd0, r_best_id});

    always_ff @(posedge i_clk) begin
        if (dir_we && byte_take) dir_mem[dir_wa] <= dir_wd;
        if (dir_re) r_dir_q <= dir_mem[dir_ra];
    end

    always_ff @(posedge i_clk) begin
        if (off_we && byte_take) off_mem[off_wa] <= n_word;
        if (off_re) r_off_q <= off_mem[off_ra];
    end

    // Output valid: set on a load, drop once the receiver takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // Control and lookup sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LOAD;
            r_bytes_seen <= '0;
            r_word <= '0;
            r_dir_bytes <= '0;
            r_table_begin <= '0;
            r_entry_total <= '0;
            r_payload_start <= '0;
            r_pending <= ERR_NONE;
            r_state <= S_IDLE;
            r_dq_vld <= 1'b0;
        end else begin
            r_dq_vld <= dir_re;
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_out_num <= '0;
                        r_out_off <= '0;
                        r_out_size <= '0;
                        if (i_kind == KIND_BYTE) begin
                            if (r_phase == PH_LOAD) begin
                                r_out_status <= byte_status;
                                r_phase <= n_phase;
                                r_bytes_seen <= n_bytes_seen;
                                r_word <= n_word;
                                r_dir_bytes <= n_dir_bytes;
                                r_table_begin <= n_table_begin;
                                r_entry_total <= n_entry_total;
                                r_payload_start <= n_payload_start;
                                r_pending <= n_pending;
                                r_prev_off <= n_prev_off;
                                r_rec_lo <= n_rec_lo;
                            end else begin
                                r_out_status <= ST_IGNORED;
                            end
                        end else if (i_kind == KIND_QUERY) begin
                            if (r_phase == PH_READY) begin
                                // Hold the output slot empty until the lookup ends.
                                r_qtype <= i_query_type;
                                r_qid <= i_query_id;
                                r_scan_i <= '0;
                                r_found <= 1'b0;
                                r_state <= S_SCAN1;
                            end else begin
                                r_out_status <= ST_IGNORED;
                            end
                        end else if (i_kind == KIND_RESTART) begin
                            r_out_status <= ST_ACCEPTED;
                            r_phase <= PH_LOAD;
                            r_bytes_seen <= '0;
                            r_word <= '0;
                            r_dir_bytes <= '0;
                            r_table_begin <= '0;
                            r_entry_total <= '0;
                            r_payload_start <= '0;
                            r_pending <= ERR_NONE;
                        end else begin
                            r_out_status <= ST_IGNORED;
                        end
                    end
                end
                S_SCAN1: begin
                    if (dir_re) r_scan_i <= r_scan_i + 1'b1;
                    if (r_dq_vld && r_dir_q[15:0] == r_qtype && r_dir_q[31:16] <= r_qid &&
                        (!r_found || r_dir_q[31:16] > r_best_id)) begin
                        r_found <= 1'b1;
                        r_best_id <= r_dir_q[31:16];
                        r_best_idx <= r_dir_q[47:32];
                    end
                    if (scan_done) begin
                        if (!r_found) begin
                            r_lk_status <= ST_MISS;
                            r_state <= S_FIN;
                        end else begin
                            r_scan_i <= '0;
                            r_bound <= r_entry_total;
                            r_state <= S_SCAN2;
                        end
                    end
                end
                S_SCAN2: begin
                    if (dir_re) r_scan_i <= r_scan_i + 1'b1;
                    if (r_dq_vld && r_dir_q[47:32] > r_best_idx &&
                        {16'd0, r_dir_q[47:32]} < r_bound)
                        r_bound <= {16'd0, r_dir_q[47:32]};
                    if (scan_done) begin
                        r_cand <= cand_calc;
                        if ({14'd0, cand_calc} >= r_bound ||
                            {14'd0, cand_calc} >= 32'(MAX_ENTRIES)) begin
                            r_lk_status <= ST_MISS;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_RDA;
                        end
                    end
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    r_lk_off <= r_off_q;
                    r_state <= S_RDC;
                end
                S_RDC: begin
                    r_lk_size <= r_off_q - r_lk_off;
                    r_lk_status <= ST_HIT;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_status <= r_lk_status;
                        if (r_lk_status == ST_HIT) begin
                            r_out_num <= r_cand[9:0];
                            r_out_off <= r_lk_off;
                            r_out_size <= r_lk_size;
                        end else begin
                            r_out_num <= '0;
                            r_out_off <= '0;
                            r_out_size <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_out_status;
    assign o_entry_number = r_out_num;
    assign o_entry_offset = r_out_off;
    assign o_entry_size   = r_out_size;

`ifndef SYNTHESIS
    a_no_read_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_dq_vld)
        else $error("directory read data pending outside a scan");
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken during a lookup");
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_HIT) |->
        (o_entry_number == 10'd0 && o_entry_offset == 32'd0 && o_entry_size == 32'd0))
        else $error("non-hit result carries entry data");
    a_ready_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_READY) |->
        (r_pending == ERR_NONE && r_entry_total <= 32'(MAX_ENTRIES)))
        else $error("ready with error pending or too many entries");
`endif

endmodule
